// ----- src/sqm_pkg.sv -----
package sqm_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OP_W   = 2;

  localparam logic [OP_W-1:0] OP_PUSH_A = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_B = 2'd1;
  localparam logic [OP_W-1:0] OP_MERGE  = 2'd2;

  localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PICK,
    ST_NONE
  } state_t;

  // (head + fill) mod depth, sum stays below twice the depth
  function automatic logic [IDX_W-1:0] tail_idx(input logic [IDX_W-1:0] head,
                                                input logic [FILL_W-1:0] fill);
    logic [FILL_W:0] sum;
    sum = (FILL_W+1)'(head) + (FILL_W+1)'(fill);
    if (sum >= (FILL_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (FILL_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] head);
    logic [IDX_W-1:0] nxt;
    if ((FILL_W+1)'(head) == (FILL_W+1)'(QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = head + IDX_W'(1);
    end
    return nxt;
  endfunction

endpackage

// ----- src/sqm_if.sv -----
interface sqm_in_if;
  logic                              valid;
  logic                              ready;
  logic [sqm_pkg::OP_W-1:0]          operation;
  logic signed [sqm_pkg::WORD_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface sqm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sqm_pkg::WORD_W-1:0] merged_value;
  logic                              last;
  logic                              nothing_merged;

  modport source (output valid, output merged_value, output last, output nothing_merged,
                  input ready);
  modport sink   (input valid, input merged_value, input last, input nothing_merged,
                  output ready);
endinterface

// ----- src/sorted_queue_merge.sv -----
// channel   dir  handshake        payload
// in_ch     in   valid / ready    operation[1:0], value[31:0] signed
// out_ch    out  valid / ready    merged_value[31:0] signed, last, nothing_merged
//
// a push request is taken in the idle state; requests are taken only between merges
// a merge handles each word in two steps: one queue memory read, then one compare and pop
// a merge of two empty queues gives its single result from the none step, once the output is free
// synchronous active-low reset clears state, pointers, fills and the output valid flag
// a stalled output holds the merge in its pick or none step; pushes still wait for the merge end
module sorted_queue_merge (
  input  logic      clk,
  input  logic      rst_n,
  sqm_in_if.sink    in_ch,
  sqm_out_if.source out_ch
);
  import sqm_pkg::*;

  logic signed [WORD_W-1:0] mem_a [QUEUE_DEPTH];
  logic signed [WORD_W-1:0] mem_b [QUEUE_DEPTH];
  logic signed [WORD_W-1:0] rd_a_r, rd_b_r;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   head_a_r, head_a_nxt, head_b_r, head_b_nxt;
  logic [FILL_W-1:0]  fill_a_r, fill_a_nxt, fill_b_r, fill_b_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [WORD_W-1:0] out_value_r, out_value_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_none_r, out_none_nxt;

  logic in_acc, out_free, take_a, wr_a, wr_b;
  logic [FILL_W:0] total;

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign in_acc                = in_ch.valid && in_ch.ready;
  assign out_free              = !out_valid_r || out_ch.ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.merged_value   = out_value_r;
  assign out_ch.last           = out_last_r;
  assign out_ch.nothing_merged = out_none_r;

  assign wr_a  = in_acc && (in_ch.operation == OP_PUSH_A) && (fill_a_r < DEPTH_F);
  assign wr_b  = in_acc && (in_ch.operation == OP_PUSH_B) && (fill_b_r < DEPTH_F);
  assign total = (FILL_W+1)'(fill_a_r) + (FILL_W+1)'(fill_b_r);

  always_comb begin
    if (fill_a_r == '0) begin
      take_a = 1'b0;
    end else if (fill_b_r == '0) begin
      take_a = 1'b1;
    end else begin
      take_a = (rd_a_r <= rd_b_r);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[tail_idx(head_a_r, fill_a_r)] <= in_ch.value;
    end
    if (wr_b) begin
      mem_b[tail_idx(head_b_r, fill_b_r)] <= in_ch.value;
    end
    rd_a_r <= mem_a[head_a_r];
    rd_b_r <= mem_b[head_b_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_a_r    <= '0;
      head_b_r    <= '0;
      fill_a_r    <= '0;
      fill_b_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_a_r    <= head_a_nxt;
      head_b_r    <= head_b_nxt;
      fill_a_r    <= fill_a_nxt;
      fill_b_r    <= fill_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_none_r  <= out_none_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    head_a_nxt    = head_a_r;
    head_b_nxt    = head_b_r;
    fill_a_nxt    = fill_a_r;
    fill_b_nxt    = fill_b_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_none_nxt  = out_none_r;

    unique case (state_r)
      ST_IDLE: begin
        if (wr_a) begin
          fill_a_nxt = fill_a_r + FILL_W'(1);
        end
        if (wr_b) begin
          fill_b_nxt = fill_b_r + FILL_W'(1);
        end
        if (in_acc && (in_ch.operation == OP_MERGE)) begin
          state_nxt = (total == '0) ? ST_NONE : ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_none_nxt  = 1'b0;
          out_last_nxt  = (total == (FILL_W+1)'(1));
          if (take_a) begin
            out_value_nxt = rd_a_r;
            head_a_nxt    = next_idx(head_a_r);
            fill_a_nxt    = fill_a_r - FILL_W'(1);
          end else begin
            out_value_nxt = rd_b_r;
            head_b_nxt    = next_idx(head_b_r);
            fill_b_nxt    = fill_b_r - FILL_W'(1);
          end
          state_nxt = (total == (FILL_W+1)'(1)) ? ST_IDLE : ST_READ;
        end
      end
      ST_NONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
          out_none_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_a_r <= DEPTH_F) && (fill_b_r <= DEPTH_F))
    else $error("queue fill beyond depth");

  a_pick_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK) |-> (total != '0))
    else $error("pick step with both queues empty");

  a_empty_merge: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.operation == OP_MERGE) && (total == '0)) |=> (state_r == ST_NONE))
    else $error("empty merge not flagged");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_none_r) |-> out_last_r)
    else $error("empty merge result not marked last");

  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK && out_free && total == (FILL_W+1)'(1)) |=>
      (fill_a_r == '0 && fill_b_r == '0 && state_r == ST_IDLE))
    else $error("queues not drained after last result");

endmodule
